// ===== rtl/core/periodic_task_scheduler_unit_macros.svh =====
// assertion macros for the periodic task scheduler
`ifndef PERIODIC_TASK_SCHEDULER_UNIT_MACROS_SVH
`define PERIODIC_TASK_SCHEDULER_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define PTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define PTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/pts_pkg.sv =====
// shared types and constants for the periodic task scheduler
`default_nettype none

package pts_pkg;

    localparam int MAX_SLOTS = 8;
    localparam int TIME_BITS = 16;
    localparam int IDX_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 4;

    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [TIME_BITS-1:0] time_t;

    // command codes
    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_LOAD    = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 1'd1;

    // policy codes
    localparam logic POLICY_RM  = 1'b0;
    localparam logic POLICY_EDF = 1'b1;

    typedef struct packed {
        logic [1:0] cmd;
        logic [2:0] slot_index;
        logic [7:0] run_length;
        logic [7:0] release_interval;
    } item_t;

    typedef struct packed {
        logic [2:0]  running_slot;
        logic        idle;
        logic [15:0] tick_time;
    } result_t;

    // best candidate handed along the cell chain
    typedef struct packed {
        logic  valid;
        time_t key;
        idx_t  idx;
    } cand_t;

    // control from the sequencer to every cell
    typedef struct packed {
        logic       release_en;
        logic       grant_en;
        logic       restart;
        logic       load_en;
        idx_t       load_slot;
        logic [7:0] cost;
        logic [7:0] interval;
        logic       policy;
        logic [3:0] active;
        time_t      now;
        idx_t       win_idx;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/pts_cell.sv =====
// one task slot: job state, release update and candidate compare
`default_nettype none

module pts_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire pts_pkg::cell_ctrl_t ctrl,
    input  wire pts_pkg::idx_t      my_idx,
    input  wire pts_pkg::cand_t     cand_in,
    output pts_pkg::cand_t          cand_out
);

    logic [7:0]     job_left_reg;
    pts_pkg::time_t release_at_reg;
    pts_pkg::time_t due_at_reg;
    logic [7:0]     cost_reg;
    logic [7:0]     interval_reg;
    pts_pkg::cand_t cand_reg;

    logic           take_part;
    logic           release_hit;
    logic           mine_valid;
    pts_pkg::time_t mine_key;
    pts_pkg::cand_t cand_next;

    // slot takes part when its index is below the active count
    assign take_part   = 32'(ctrl.active) > 32'(my_idx);
    assign release_hit = ctrl.release_en && take_part && (release_at_reg == ctrl.now);

    // priority key: period for rate monotonic, deadline distance for edf
    assign mine_valid = take_part && (job_left_reg != 8'd0);
    assign mine_key   = (ctrl.policy == pts_pkg::POLICY_EDF)
                      ? pts_pkg::time_t'(due_at_reg - ctrl.now)
                      : pts_pkg::time_t'(interval_reg);

    // keep the incoming candidate on ties so the lower index wins
    always_comb
    begin
        cand_next = cand_in;
        if (mine_valid && (!cand_in.valid || (mine_key < cand_in.key)))
        begin
            cand_next.valid = 1'b1;
            cand_next.key   = mine_key;
            cand_next.idx   = my_idx;
        end
    end

    assign cand_out = cand_reg;

    // slot state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_left_reg   <= '0;
            release_at_reg <= '0;
            cost_reg       <= '0;
            interval_reg   <= 8'd1;
            cand_reg       <= '0;
        end
        else
        begin
            cand_reg <= cand_next;
            if (ctrl.restart)
            begin
                job_left_reg   <= '0;
                release_at_reg <= '0;
            end
            else if (release_hit)
            begin
                job_left_reg   <= cost_reg;
                release_at_reg <= pts_pkg::time_t'(release_at_reg
                                  + pts_pkg::time_t'(interval_reg));
            end
            else if (ctrl.grant_en && (ctrl.win_idx == my_idx))
            begin
                job_left_reg <= job_left_reg - 8'd1;
            end
            if (ctrl.load_en && (ctrl.load_slot == my_idx))
            begin
                cost_reg     <= ctrl.cost;
                interval_reg <= (ctrl.interval == 8'd0) ? 8'd1 : ctrl.interval;
            end
        end
    end

    // deadline, written at each release
    always_ff @(posedge clk)
    begin
        if (release_hit)
        begin
            due_at_reg <= pts_pkg::time_t'(ctrl.now + pts_pkg::time_t'(interval_reg));
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/pts_seq.sv =====
// command sequencer: configuration, time, chain walk and result register
`default_nettype none

module pts_seq (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire pts_pkg::item_t                     item,
    input  wire logic                               cfg_we,
    input  wire logic [pts_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [pts_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire pts_pkg::cand_t                     win,
    output logic                                    busy,
    output pts_pkg::cell_ctrl_t                     ctrl,
    output logic                                    done,
    output pts_pkg::result_t                        result
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_GRANT
    } state_t;

    localparam pts_pkg::idx_t LAST_STEP = pts_pkg::idx_t'(pts_pkg::MAX_SLOTS - 1);

    state_t           state_reg;
    pts_pkg::idx_t    walk_cnt_reg;
    pts_pkg::time_t   now_reg;
    logic             policy_reg;
    logic [3:0]       active_reg;
    logic             done_reg;
    pts_pkg::result_t result_reg;

    logic accept;
    logic slot_ok;

    assign accept  = start && (state_reg == ST_IDLE);
    assign slot_ok = 32'(item.slot_index) < pts_pkg::MAX_SLOTS;
    assign busy    = (state_reg != ST_IDLE);
    assign done    = done_reg;
    assign result  = result_reg;

    // control fanned out to the cells
    always_comb
    begin
        ctrl.release_en = accept && (item.cmd == pts_pkg::CMD_TICK);
        ctrl.load_en    = accept && (item.cmd == pts_pkg::CMD_LOAD) && slot_ok;
        ctrl.restart    = accept && (item.cmd == pts_pkg::CMD_RESTART);
        ctrl.grant_en   = (state_reg == ST_GRANT) && win.valid;
        ctrl.load_slot  = pts_pkg::idx_t'(item.slot_index);
        ctrl.cost       = item.run_length;
        ctrl.interval   = item.release_interval;
        ctrl.policy     = policy_reg;
        ctrl.active     = active_reg;
        ctrl.now        = now_reg;
        ctrl.win_idx    = win.idx;
    end

    // state, time, configuration and result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            walk_cnt_reg <= '0;
            now_reg      <= '0;
            policy_reg   <= pts_pkg::POLICY_RM;
            active_reg   <= '0;
            done_reg     <= 1'b0;
            result_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    pts_pkg::CFG_POLICY: policy_reg <= cfg_data[0];
                    pts_pkg::CFG_ACTIVE: active_reg <= cfg_data;
                    default: ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (ctrl.restart)
                    begin
                        now_reg <= '0;
                    end
                    if (ctrl.release_en)
                    begin
                        walk_cnt_reg <= '0;
                        state_reg    <= ST_WALK;
                    end
                end
                ST_WALK:
                begin
                    walk_cnt_reg <= walk_cnt_reg + pts_pkg::idx_t'(1);
                    if (walk_cnt_reg == LAST_STEP)
                    begin
                        state_reg <= ST_GRANT;
                    end
                end
                ST_GRANT:
                begin
                    done_reg                <= 1'b1;
                    result_reg.running_slot <= win.valid ? 3'(win.idx) : 3'd0;
                    result_reg.idle         <= !win.valid;
                    result_reg.tick_time    <= 16'(now_reg);
                    now_reg                 <= now_reg + pts_pkg::time_t'(1);
                    state_reg               <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/periodic_task_scheduler_unit.sv =====
// Top level: periodic task scheduler, a chain of slot cells and a sequencer.
// A tick transfer walks the best candidate down the cell chain, then gives its result strobe.
// A new command is taken only while idle, so a tick finishes its walk before the next one starts.
// Load and restart transfers give no result.
// Results are shown for one cycle on done; the receiver cannot stall.
// Reset clears time, jobs, releases, costs, periods to one, and configuration.
`default_nettype none

module periodic_task_scheduler_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire pts_pkg::item_t                 item,
    output logic                                busy,
    output logic                                done,
    output pts_pkg::result_t                    result,
    input  wire logic                           cfg_we,
    input  wire logic [pts_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pts_pkg::CFG_DATA_W-1:0] cfg_data
);

    pts_pkg::cell_ctrl_t ctrl;
    pts_pkg::cand_t      chain [pts_pkg::MAX_SLOTS];

    // sequencer
    pts_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .win       (chain[pts_pkg::MAX_SLOTS-1]),
        .busy      (busy),
        .ctrl      (ctrl),
        .done      (done),
        .result    (result)
    );

    // row of slot cells, candidate moves one cell per cycle
    for (genvar i = 0; i < pts_pkg::MAX_SLOTS; i++)
    begin : g_cell
        pts_pkg::cand_t cand_in;
        if (i == 0)
        begin : g_head
            assign cand_in = '0;
        end
        else
        begin : g_link
            assign cand_in = chain[i-1];
        end
        pts_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .my_idx   (pts_pkg::idx_t'(i)),
            .cand_in  (cand_in),
            .cand_out (chain[i])
        );
    end

`include "periodic_task_scheduler_unit_macros.svh"

    `PTS_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while still busy")
    `PTS_ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")
    `PTS_ASSERT_NEXT(a_tick_busy, start && !busy && (item.cmd == pts_pkg::CMD_TICK), busy, "tick transfer did not start the walk")
    `PTS_ASSERT_NEXT(a_other_quiet, start && !busy && (item.cmd != pts_pkg::CMD_TICK), !busy && !done, "non-tick transfer gave a result or went busy")

endmodule

`default_nettype wire

// ===== verif/tb_periodic_task_scheduler_unit.sv =====
// testbench for the periodic task scheduler: directed and random commands checked per tick
`timescale 1ns / 1ps

module tb_periodic_task_scheduler_unit;
    import pts_pkg::*;

    localparam int          CLK_HALF      = 2;
    localparam int          RESET_CYCLES  = 8;
    localparam int          TICK_LATENCY  = MAX_SLOTS + 2;
    localparam int          SETTLE_CYCLES = TICK_LATENCY + 4;
    localparam int          RANDOM_ITEMS  = 1200;
    localparam int          DRAIN_LIMIT   = 1000;
    localparam int          TIMEOUT_NS    = 2_000_000;
    localparam logic [1:0]  CMD_UNUSED    = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    item_t                 item;
    logic                  busy;
    logic                  done;
    result_t               result;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // scheduler state mirrored by the predictor
    logic       sched_policy;
    logic [3:0] sched_active;
    time_t      sched_now;
    logic [7:0] work_left       [MAX_SLOTS];
    time_t      pending_release [MAX_SLOTS];
    time_t      deadline        [MAX_SLOTS];
    logic [7:0] slot_cost       [MAX_SLOTS];
    logic [7:0] slot_period     [MAX_SLOTS];

    result_t expected_ticks[$];
    int      mismatches = 0;
    bit      use_gaps   = 1'b1;

    periodic_task_scheduler_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_HALF) clk = ~clk;

    // predictor state after reset
    function automatic void reset_schedule();
        sched_policy = POLICY_RM;
        sched_active = '0;
        sched_now    = '0;
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            work_left[i]       = '0;
            pending_release[i] = '0;
            deadline[i]        = '0;
            slot_cost[i]       = '0;
            slot_period[i]     = 8'd1;
        end
    endfunction

    // apply one accepted command, queue the tick result it produces
    function automatic void schedule_command(input item_t it);
        int      count;
        int      chosen;
        time_t   key;
        time_t   best_key;
        result_t r;
        case (it.cmd)
            CMD_LOAD:
            begin
                if (it.slot_index < MAX_SLOTS)
                begin
                    slot_cost[it.slot_index]   = it.run_length;
                    slot_period[it.slot_index] =
                        (it.release_interval == 8'd0) ? 8'd1 : it.release_interval;
                end
            end
            CMD_RESTART:
            begin
                sched_now = '0;
                for (int i = 0; i < MAX_SLOTS; i++)
                begin
                    work_left[i]       = '0;
                    pending_release[i] = '0;
                end
            end
            CMD_TICK:
            begin
                count    = (sched_active > MAX_SLOTS) ? MAX_SLOTS : int'(sched_active);
                chosen   = -1;
                best_key = '0;
                // releases: fresh job replaces any unfinished one
                for (int i = 0; i < count; i++)
                begin
                    if (pending_release[i] == sched_now)
                    begin
                        work_left[i]       = slot_cost[i];
                        deadline[i]        = sched_now + time_t'(slot_period[i]);
                        pending_release[i] = pending_release[i] + time_t'(slot_period[i]);
                    end
                end
                // pick the ready slot with the smallest key, lowest index on ties
                for (int i = 0; i < count; i++)
                begin
                    if (work_left[i] != 8'd0)
                    begin
                        key = (sched_policy == POLICY_EDF) ? time_t'(deadline[i] - sched_now)
                                                           : time_t'(slot_period[i]);
                        if (chosen < 0 || key < best_key)
                        begin
                            chosen   = i;
                            best_key = key;
                        end
                    end
                end
                if (chosen >= 0)
                begin
                    work_left[chosen] = work_left[chosen] - 8'd1;
                    r.running_slot    = chosen[2:0];
                    r.idle            = 1'b0;
                end
                else
                begin
                    r.running_slot = '0;
                    r.idle         = 1'b1;
                end
                r.tick_time = sched_now[15:0];
                expected_ticks.push_back(r);
                sched_now = sched_now + time_t'(1);
            end
            default: ;
        endcase
    endfunction

    function automatic item_t make_item(input logic [1:0] cmd, input int slot,
                                        input int cost, input int period);
        item_t it;
        it.cmd              = cmd;
        it.slot_index       = slot[2:0];
        it.run_length       = cost[7:0];
        it.release_interval = period[7:0];
        return it;
    endfunction

    // mostly ticks with some loads, the odd restart and unused code
    function automatic item_t random_item();
        item_t it;
        int    pick;
        pick                = $urandom_range(0, 99);
        it.slot_index       = 3'($urandom_range(0, 7));
        it.run_length       = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                          : 8'($urandom_range(0, 6));
        it.release_interval = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                          : 8'($urandom_range(1, 12));
        if (pick < 75)
            it.cmd = CMD_TICK;
        else if (pick < 94)
            it.cmd = CMD_LOAD;
        else if (pick < 97)
            it.cmd = CMD_RESTART;
        else
            it.cmd = CMD_UNUSED;
        return it;
    endfunction

    // one command transfer, with optional idle cycles ahead of it
    task automatic send_item(input item_t it);
        int gap;
        gap = use_gaps ? $urandom_range(0, 9) : 0;
        @(negedge clk);
        if (use_gaps && $urandom_range(0, 1) == 1)
        begin
            while (busy)
            begin
                start <= 1'b0;
                @(negedge clk);
            end
        end
        repeat (gap)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        item  <= it;
        while (busy)
            @(negedge clk);
        @(posedge clk);
        schedule_command(it);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_POLICY)
            sched_policy = data[0];
        else if (idx == CFG_ACTIVE)
            sched_active = data;
    endtask

    // block idle: every tick result in and a load or restart fully settled
    task automatic wait_quiet();
        @(negedge clk);
        start <= 1'b0;
        while (expected_ticks.size() != 0 || busy)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    task automatic send_tick();
        send_item(make_item(CMD_TICK, 0, 0, 0));
    endtask

    // reset values: no slot takes part, unused code ignored
    task automatic test_idle_after_reset();
        send_tick();
        send_item(make_item(CMD_UNUSED, 5, 170, 85));
        send_tick();
    endtask

    // rate monotonic with extreme costs, zero period and equal periods
    task automatic test_rate_monotonic();
        wait_quiet();
        write_reg(CFG_POLICY, {3'b000, POLICY_RM});
        write_reg(CFG_ACTIVE, 4'd8);
        send_item(make_item(CMD_LOAD, 0, 255, 255));
        send_item(make_item(CMD_LOAD, 3, 2, 4));
        send_item(make_item(CMD_LOAD, 5, 0, 0));
        send_item(make_item(CMD_LOAD, 6, 3, 3));
        send_item(make_item(CMD_LOAD, 7, 1, 3));
        send_item(make_item(CMD_RESTART, 0, 0, 0));
        repeat (6)
            send_tick();
    endtask

    // deadline ordering with the slot count above the number of slots
    task automatic test_deadline_first();
        wait_quiet();
        write_reg(CFG_POLICY, {3'b111, POLICY_EDF});
        write_reg(CFG_ACTIVE, 4'd15);
        send_item(make_item(CMD_LOAD, 1, 3, 5));
        send_item(make_item(CMD_LOAD, 4, 2, 3));
        send_item(make_item(CMD_RESTART, 7, 255, 255));
        repeat (5)
            send_tick();
    endtask

    // phases of random commands, each starting from a fresh task set
    task automatic test_random_phases();
        int          sent;
        int          phase;
        item_t       it;
        logic [3:0]  active;
        logic        policy;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            wait_quiet();
            case (phase)
                0:       active = 4'd0;
                1:       active = 4'd8;
                2:       active = 4'd15;
                3:       active = 4'd1;
                default: active = 4'($urandom_range(0, 15));
            endcase
            policy = (phase < 4) ? phase[0] : 1'($urandom_range(0, 1));
            write_reg(CFG_POLICY, {3'($urandom_range(0, 7)), policy});
            write_reg(CFG_ACTIVE, active);
            use_gaps = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 1) == 1)
            begin
                send_item(make_item(CMD_RESTART, $urandom_range(0, 7), 0, 0));
                sent++;
            end
            for (int s = 0; s < MAX_SLOTS; s++)
            begin
                send_item(make_item(CMD_LOAD, s, $urandom_range(0, 5), $urandom_range(1, 16)));
                sent++;
            end
            repeat ($urandom_range(60, 140))
            begin
                it = random_item();
                send_item(it);
                if (it.cmd != CMD_UNUSED)
                    sent++;
            end
            phase++;
        end
        use_gaps = 1'b1;
    endtask

    // late joining slots: release time already passed, they stay out until time comes round
    task automatic test_time_wrap();
        wait_quiet();
        use_gaps = 1'b0;
        write_reg(CFG_POLICY, {3'b000, POLICY_EDF});
        write_reg(CFG_ACTIVE, 4'd4);
        send_item(make_item(CMD_RESTART, 0, 0, 0));
        for (int s = 0; s < MAX_SLOTS; s++)
            send_item(make_item(CMD_LOAD, s, $urandom_range(1, 3), $urandom_range(4, 24)));
        repeat (40)
            send_tick();
        wait_quiet();
        write_reg(CFG_ACTIVE, 4'd8);
        repeat (120)
            send_tick();
        wait_quiet();
        write_reg(CFG_POLICY, {3'b000, POLICY_RM});
        repeat (80)
            send_tick();
        use_gaps = 1'b1;
    endtask

    // compare every tick result against the oldest prediction
    always @(posedge clk)
    begin : check_ticks
        result_t want;
        if (rst_n && done)
        begin
            if (expected_ticks.size() == 0)
            begin
                $error("unexpected tick result: running_slot %0d idle %0d tick_time %0d",
                       result.running_slot, result.idle, result.tick_time);
                mismatches++;
            end
            else
            begin
                want = expected_ticks.pop_front();
                if (result.running_slot !== want.running_slot)
                begin
                    $error("running_slot: expected %0d, actual %0d",
                           want.running_slot, result.running_slot);
                    mismatches++;
                end
                if (result.idle !== want.idle)
                begin
                    $error("idle: expected %0d, actual %0d", want.idle, result.idle);
                    mismatches++;
                end
                if (result.tick_time !== want.tick_time)
                begin
                    $error("tick_time: expected %0d, actual %0d",
                           want.tick_time, result.tick_time);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int drain;
        rst_n     = 1'b0;
        start     = 1'b0;
        item      = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        reset_schedule();
        repeat (RESET_CYCLES)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_idle_after_reset();
        test_rate_monotonic();
        test_deadline_first();
        test_random_phases();
        test_time_wrap();

        // drain outstanding tick results
        @(negedge clk);
        start <= 1'b0;
        drain = 0;
        while (expected_ticks.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(negedge clk);
            drain++;
        end
        repeat (SETTLE_CYCLES)
            @(negedge clk);
        if (expected_ticks.size() != 0)
        begin
            $error("%0d tick results never arrived", expected_ticks.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
